@@ rtl/core/fcd_pkg.sv @@
// Shared types and constants for the FAST corner detector.
// Used by every module under rtl/core except fcd_ram; depends on nothing.

package fcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int LINES      = 6;
  localparam int WIN        = 7;
  localparam int LINE_W     = LINES * PIX_W;
  localparam int DIM_W      = 11;
  localparam int MARGIN_W   = 9;
  localparam int THR_W      = 9;
  localparam int ARC_W      = 4;
  localparam int CIRC_N     = 16;
  localparam int IDX_W      = 3;
  localparam int SUM_W      = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

  // Circle points as window coordinates, clockwise from straight above the center.
  localparam logic [2:0] CIRC_X [CIRC_N] = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
                                             3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};
  localparam logic [2:0] CIRC_Y [CIRC_N] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
                                             3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_BORDER_MARGIN = 3'd2,
    REG_THRESHOLD_Q8  = 3'd3,
    REG_MIN_GRAY_DIFF = 3'd4,
    REG_ARC_LENGTH    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [MARGIN_W-1:0] border_margin;
    logic [THR_W-1:0]    threshold_q8;
    logic [PIX_W-1:0]    min_gray_diff;
    logic [ARC_W-1:0]    arc_length;
  } cfg_t;

  // Position of one pixel and whether its trailing center gets a result.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             emit;
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] cr;
  } pos_t;

  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;

endpackage

@@ rtl/core/fcd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.

module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/fcd_scan.sv @@
// Raster position counters and border-margin check for each incoming pixel.
// Depends on fcd_pkg.

module fcd_scan import fcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  logic sof,
  output pos_t pos
);

  logic [COL_W-1:0]    col_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    col_count_next;
  logic [ROW_W-1:0]    row_count_next;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [DIM_W-1:0]    w;
  logic [DIM_W-1:0]    h;
  logic [MARGIN_W-1:0] m;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [SUM_W-1:0]    cc_ext;
  logic [SUM_W-1:0]    cr_ext;
  logic [SUM_W-1:0]    m_ext;

  always_comb begin
    w = (32'(cfg.image_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.image_width;
    h = (32'(cfg.image_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg.image_height;
    m = (cfg.border_margin < MARGIN_W'(3)) ? MARGIN_W'(3) : cfg.border_margin;

    col = sof ? '0 : col_count;
    row = sof ? '0 : row_count;

    // The center trails the newest pixel by three rows and three columns.
    pos.col  = col;
    pos.cc   = col - COL_W'(3);
    pos.cr   = row - ROW_W'(3);
    cc_ext   = SUM_W'(pos.cc);
    cr_ext   = SUM_W'(pos.cr);
    m_ext    = SUM_W'(m);
    pos.emit = (col >= COL_W'(3)) && (row >= ROW_W'(3)) &&
               (cc_ext >= m_ext) && (cr_ext >= m_ext) &&
               ((cc_ext + m_ext) < SUM_W'(w)) && ((cr_ext + m_ext) < SUM_W'(h));

    col_inc = {1'b0, col} + (COL_W+1)'(1);
    row_inc = {1'b0, row} + (ROW_W+1)'(1);
    if (SUM_W'(col_inc) >= SUM_W'(w)) begin
      col_count_next = '0;
      row_count_next = (SUM_W'(row_inc) >= SUM_W'(h)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

@@ rtl/core/fcd_window.sv @@
// Line stores and the 7x7 pixel window; first two pipeline stages of the detector.
// Depends on fcd_pkg and fcd_ram.

module fcd_window import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [COL_W-1:0] col,
  input  logic [PIX_W-1:0] pixel,
  input  logic             shift,
  output window_t          win
);

  logic [PIX_W-1:0]  pix1;
  logic [COL_W-1:0]  col1;
  logic              fwd1;
  logic [LINE_W-1:0] fwd_data1;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_word;
  logic [LINE_W-1:0] wr_word;
  logic [PIX_W-1:0]  colv [WIN];

  // One word holds the six stored rows of a column, oldest row in the low byte.
  fcd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (shift),
    .waddr (col1),
    .wdata (wr_word),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_comb begin
    // A read issued in the cycle that writes the same column sees old data.
    line_word = fwd1 ? fwd_data1 : ram_rdata;
    wr_word   = {pix1, line_word[LINE_W-1:PIX_W]};
    for (int k = 0; k < LINES; k++) begin
      colv[k] = line_word[k*PIX_W +: PIX_W];
    end
    colv[LINES] = pix1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd1 <= 1'b0;
    end else if (accept) begin
      fwd1 <= shift && (col1 == col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1      <= pixel;
      col1      <= col;
      fwd_data1 <= wr_word;
    end
    if (shift) begin
      for (int y = 0; y < WIN; y++) begin
        for (int x = 0; x < WIN - 1; x++) begin
          win[y][x] <= win[y][x+1];
        end
        win[y][WIN-1] <= colv[y];
      end
    end
  end

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    !shift |=> $stable(win)) else $error("window changed without a shift");

  a_forward_set: assert property (@(posedge clk) disable iff (rst)
    (accept && shift && (col1 == col)) |=> fwd1)
    else $error("same-column read after write not forwarded");

endmodule

@@ rtl/core/fcd_seg_test.sv @@
// Segment test: band classification of the 16 circle pixels, then the arc-run check.
// Depends on fcd_pkg.

module fcd_seg_test import fcd_pkg::*; (
  input  logic    clk,
  input  cfg_t    cfg,
  input  window_t win,
  input  logic    load_cls,
  input  logic    load_out,
  output logic    is_corner
);

  logic [PIX_W-1:0]    center;
  logic [THR_W-1:0]    thr;
  logic [2*PIX_W:0]    prod;
  logic [PIX_W-1:0]    rel;
  logic [PIX_W-1:0]    diff;
  logic [PIX_W:0]      hi;
  logic [PIX_W-1:0]    v;
  logic [CIRC_N-1:0]   bright;
  logic [CIRC_N-1:0]   dark;
  logic [CIRC_N-1:0]   bright_q;
  logic [CIRC_N-1:0]   dark_q;
  logic [ARC_W-1:0]    need;
  logic [CIRC_N-1:0]   mask;
  logic [2*CIRC_N-1:0] bb;
  logic [2*CIRC_N-1:0] dd;
  logic                hit;

  always_comb begin
    center = win[3][3];
    thr    = (cfg.threshold_q8 > THR_W'(256)) ? THR_W'(256) : cfg.threshold_q8;
    prod   = (2*PIX_W+1)'(thr * center);
    rel    = prod[2*PIX_W-1:PIX_W];
    diff   = (cfg.min_gray_diff > rel) ? cfg.min_gray_diff : rel;
    hi     = {1'b0, center} + {1'b0, diff};
    bright = '0;
    dark   = '0;
    v      = '0;
    for (int i = 0; i < CIRC_N; i++) begin
      v         = win[CIRC_Y[i]][CIRC_X[i]];
      bright[i] = {1'b0, v} > hi;
      // v < center - diff, kept unsigned.
      dark[i]   = ({1'b0, v} + {1'b0, diff}) < {1'b0, center};
    end
  end

  always_ff @(posedge clk) begin
    if (load_cls) begin
      bright_q <= bright;
      dark_q   <= dark;
    end
  end

  // A cyclic run of need set bits exists when some rotation has the low need bits set.
  always_comb begin
    need = (cfg.arc_length == '0) ? ARC_W'(1) : cfg.arc_length;
    mask = (CIRC_N'(1) << need) - CIRC_N'(1);
    bb   = {bright_q, bright_q};
    dd   = {dark_q, dark_q};
    hit  = 1'b0;
    for (int i = 0; i < CIRC_N; i++) begin
      hit = hit || ((bb[i +: CIRC_N] & mask) == mask) || ((dd[i +: CIRC_N] & mask) == mask);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_corner <= hit;
    end
  end

endmodule

@@ rtl/core/fast_corner_detector_unit.sv @@
// Top level of the streaming FAST corner detector: config registers, pipeline control.
// Depends on fcd_pkg, fcd_scan, fcd_window, fcd_seg_test (and fcd_ram below it).
//
//  channel | direction | item                     | accepted when
//  --------+-----------+--------------------------+-------------------------
//  s_*     | in        | one gray pixel           | s_tvalid && s_tready
//  m_*     | out       | one corner verdict       | m_tvalid && m_tready
//  cfg_*   | in        | one register write       | cfg_wr_en
//
// One pixel is taken per clock unless a stall backs up to the input; the line memory
// read and write at one column per cycle set that rate. A verdict passes the line
// memory read, window shift, band classification and arc check registers in turn.
// Pixels whose center lies in the border produce no output item.
// Reset (rst, synchronous) clears the position counters and pipeline valids and
// loads the default registers; the line memory is not cleared.
// A stall on m_tready backs up through the stages; s_tready drops once all are full.

module fast_corner_detector_unit import fcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel
  input  logic                  s_tuser,   // [0] start_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [0] is_corner, [10:1] center_col,
                                           // [20:11] center_row, [23:21] zero
  input  logic                  cfg_wr_en,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  cfg_t    cfg;
  pos_t    pos;
  window_t win;

  logic             accept;
  logic             s1_valid;
  logic             s2_valid;
  logic             s3_valid;
  logic             s1_adv;
  logic             s2_adv;
  logic             s3_adv;
  logic             s2_free;
  logic             s3_free;
  logic             out_take;
  pos_t             s1_pos;
  logic [COL_W-1:0] s2_cc;
  logic [ROW_W-1:0] s2_cr;
  logic [COL_W-1:0] s3_cc;
  logic [ROW_W-1:0] s3_cr;
  logic [COL_W-1:0] out_cc;
  logic [ROW_W-1:0] out_cr;
  logic             is_corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= DIM_W'(640);
      cfg.image_height  <= DIM_W'(480);
      cfg.border_margin <= MARGIN_W'(10);
      cfg.threshold_q8  <= THR_W'(51);
      cfg.min_gray_diff <= PIX_W'(10);
      cfg.arc_length    <= ARC_W'(12);
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        REG_BORDER_MARGIN: cfg.border_margin <= cfg_data[MARGIN_W-1:0];
        REG_THRESHOLD_Q8:  cfg.threshold_q8  <= cfg_data[THR_W-1:0];
        REG_MIN_GRAY_DIFF: cfg.min_gray_diff <= cfg_data[PIX_W-1:0];
        REG_ARC_LENGTH:    cfg.arc_length    <= cfg_data[ARC_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is empty or moving too.
  always_comb begin
    out_take = !m_tvalid || m_tready;
    s3_adv   = s3_valid && out_take;
    s3_free  = !s3_valid || out_take;
    s2_adv   = s2_valid && s3_free;
    s2_free  = !s2_valid || s3_free;
    s1_adv   = s1_valid && s2_free;
    s_tready = !s1_valid || s2_free;
    accept   = s_tvalid && s_tready;
  end

  fcd_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .sof    (s_tuser),
    .pos    (pos)
  );

  fcd_window u_window (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .col    (pos.col),
    .pixel  (s_tdata),
    .shift  (s1_adv),
    .win    (win)
  );

  fcd_seg_test u_seg_test (
    .clk       (clk),
    .cfg       (cfg),
    .win       (win),
    .load_cls  (s2_adv),
    .load_out  (s3_adv),
    .is_corner (is_corner)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      // Every pixel shifts the window; only centers inside the margin go on.
      if (s1_adv) begin
        s2_valid <= s1_pos.emit;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid <= 1'b1;
      end else if (s3_adv) begin
        s3_valid <= 1'b0;
      end
      if (s3_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= pos;
    end
    if (s1_adv) begin
      s2_cc <= s1_pos.cc;
      s2_cr <= s1_pos.cr;
    end
    if (s2_adv) begin
      s3_cc <= s2_cc;
      s3_cr <= s2_cr;
    end
    if (s3_adv) begin
      out_cc <= s3_cc;
      out_cr <= s3_cr;
    end
  end

  assign m_tdata = {3'b000, out_cr, out_cc, is_corner};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_free) |-> !s_tready) else $error("input taken into a blocked stage");

  a_s2_to_s3: assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> s3_valid) else $error("classified item lost");

  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    s3_adv |=> m_tvalid) else $error("verdict lost before output");

endmodule

@@ tb/sv/fast_corner_detector_unit_tb.sv @@
// Self-checking testbench for fast_corner_detector_unit: streams gray pixel frames,
// predicts verdicts in a behavioral model or takes them from hand-built scenes, and
// checks each output item. Depends on fcd_pkg and the RTL under rtl/core; reads no files.
`timescale 1ns / 1ps

module fast_corner_detector_unit_tb;
  import fcd_pkg::*;

  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int RX_HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES     = 12;
  localparam int PREDICTED         = 2;
  localparam int RANDOM_PIXELS     = 1400;

  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // Circle around the center, clockwise from straight above.
  localparam int RING_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int RING_DY [16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

  // Sender idle and receiver stall odds, in percent, per idling mode.
  localparam int IDLE_PCT  [4] = '{0, 66, 0, 27};
  localparam int STALL_PCT [4] = '{0, 0, 66, 27};

  typedef enum {TEXTURE_NOISE, TEXTURE_SPOTS} texture_t;

  typedef struct packed {
    logic             corner;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } verdict_t;

  // One hand-built 7x7 frame: ring pixels take the bright or dark value by mask.
  typedef struct {
    int         thr;
    int         mind;
    int         arc;
    logic [7:0] center;
    logic [7:0] bright;
    logic [7:0] dark;
    logic [7:0] fill;
    logic [15:0] bright_ring;
    logic [15:0] dark_ring;
    int         verdict;
  } scene_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;    // [7:0] pixel
  logic             s_tuser = 1'b0;  // [0] start_of_frame
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;         // [0] is_corner, [10:1] center_col, [20:11] center_row
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  fast_corner_detector_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [7:0] line_mem [LINES][MAX_WIDTH];
  logic [7:0] win_buf [WIN][WIN];
  int cfg_w, cfg_h, cfg_m, cfg_thr, cfg_mind, cfg_arc;
  int pos_col, pos_row;
  verdict_t pending_verdicts [$];
  int forced_corner = -1;

  int idle_pct = 0;
  int stall_pct = 0;
  int holdoff_seq = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  bit rx_hold_done = 1'b0;

  int failures = 0;
  int quiet_cycles = 0;
  int pixels_sent = 0;
  int random_pixels = 0;
  int verdicts_checked = 0;
  int corners_seen = 0;
  int phases_run = 0;

  scene_t scenes [16];

  function automatic bit segment_corner();
    int center, thr, rel, diff, need, v, run_hi, run_lo, cls;
    int ring_class [16];
    bit hit;
    center = win_buf[3][3];
    thr = (cfg_thr > 256) ? 256 : cfg_thr;
    rel = (thr * center) >> 8;
    diff = (cfg_mind > rel) ? cfg_mind : rel;
    need = (cfg_arc == 0) ? 1 : cfg_arc;
    for (int i = 0; i < 16; i++) begin
      v = win_buf[3 + RING_DY[i]][3 + RING_DX[i]];
      ring_class[i] = (v > center + diff) ? 1 : ((v < center - diff) ? -1 : 0);
    end
    // Walking the ring twice catches runs that wrap past the top.
    hit = 1'b0;
    run_hi = 0;
    run_lo = 0;
    for (int i = 0; i < 32; i++) begin
      cls = ring_class[i % 16];
      run_hi = (cls == 1) ? run_hi + 1 : 0;
      run_lo = (cls == -1) ? run_lo + 1 : 0;
      if (run_hi >= need || run_lo >= need) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void predict_pixel(logic [7:0] pix, logic sof);
    int w, h, m, col, row, cc, cr;
    logic [7:0] column [WIN];
    verdict_t v;
    w = (cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w;
    h = (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h;
    m = (cfg_m < 3) ? 3 : cfg_m;
    if (sof) begin
      pos_col = 0;
      pos_row = 0;
    end
    col = pos_col % MAX_WIDTH;
    row = pos_row;
    for (int k = 0; k < LINES; k++) column[k] = line_mem[k][col];
    column[LINES] = pix;
    for (int k = 0; k < LINES; k++) line_mem[k][col] = column[k + 1];
    for (int y = 0; y < WIN; y++) begin
      for (int x = 0; x < WIN - 1; x++) win_buf[y][x] = win_buf[y][x + 1];
      win_buf[y][WIN - 1] = column[y];
    end
    if (col >= 3 && row >= 3) begin
      cc = col - 3;
      cr = row - 3;
      if (cc >= m && cr >= m && cc + m < w && cr + m < h) begin
        v.corner = (forced_corner < 0) ? segment_corner() : forced_corner[0];
        v.col = cc[COL_W-1:0];
        v.row = cr[ROW_W-1:0];
        pending_verdicts.push_back(v);
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    if (row >= MAX_HEIGHT) row = 0;
    pos_col = col;
    pos_row = row;
  endfunction

  function automatic logic [7:0] texture_pixel(texture_t tex, int base);
    int v;
    if (tex == TEXTURE_NOISE || $urandom_range(9) == 0) v = $urandom_range(255);
    else v = base + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] scene_pixel(scene_t s, int x, int y);
    logic [7:0] v;
    v = s.fill;
    if (x == 3 && y == 3) v = s.center;
    for (int i = 0; i < 16; i++) begin
      if (x == 3 + RING_DX[i] && y == 3 + RING_DY[i]) begin
        if (s.bright_ring[i]) v = s.bright;
        else if (s.dark_ring[i]) v = s.dark;
      end
    end
    return v;
  endfunction

  // Leaves cfg_wr_en high so back-to-back writes need one assignment per step.
  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   cfg_w    = value & ((1 << DIM_W) - 1);
      REG_IMAGE_HEIGHT:  cfg_h    = value & ((1 << DIM_W) - 1);
      REG_BORDER_MARGIN: cfg_m    = value & ((1 << MARGIN_W) - 1);
      REG_THRESHOLD_Q8:  cfg_thr  = value & ((1 << THR_W) - 1);
      REG_MIN_GRAY_DIFF: cfg_mind = value & ((1 << PIX_W) - 1);
      REG_ARC_LENGTH:    cfg_arc  = value & ((1 << ARC_W) - 1);
      default: ;
    endcase
  endtask

  task automatic apply_config(int w, int h, int m, int thr, int mind, int arc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BORDER_MARGIN, m);
    write_reg(REG_THRESHOLD_Q8, thr);
    write_reg(REG_MIN_GRAY_DIFF, mind);
    write_reg(REG_ARC_LENGTH, arc);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_pixel(logic [7:0] pix, logic sof);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(pix, sof);
    pixels_sent++;
  endtask

  // Idle until every predicted verdict has come out, then let the pipeline
  // empty of pixels whose centers produce nothing.
  task automatic drain_verdicts();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling();
    idle_pct  = IDLE_PCT[phases_run % 4];
    stall_pct = STALL_PCT[phases_run % 4];
    phases_run++;
  endtask

  task automatic run_phase(int w, int h, int m, int thr, int mind, int arc, int count,
                           texture_t tex, bit broken, bit pause_mid, bit hold_rx);
    int base, frame_len;
    bit sof;
    set_idling();
    apply_config(w, h, m, thr, mind, arc);
    base = $urandom_range(255);
    frame_len = ((w > MAX_WIDTH) ? MAX_WIDTH : w) * ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    for (int i = 0; i < count; i++) begin
      // Later frames either restart explicitly or rely on the row wrap; broken phases also restart at random.
      sof = (i == 0) || (frame_len > 0 && i % frame_len == 0 && $urandom_range(1) == 0)
            || (broken && $urandom_range(199) == 0);
      if (pause_mid && i == count / 2) drain_verdicts();
      if (hold_rx && !rx_hold_done && pending_verdicts.size() != 0) begin
        holdoff_seq++;
        rx_hold_done = 1'b1;
      end
      push_pixel(texture_pixel(tex, base), sof);
    end
    drain_verdicts();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (holdoff_served != holdoff_seq) begin
      holdoff_served = holdoff_seq;
      holdoff_left = RX_HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (m_tvalid && m_tready) begin
        got.corner = m_tdata[0];
        got.col    = m_tdata[10:1];
        got.row    = m_tdata[20:11];
        if (pending_verdicts.size() == 0) begin
          $error("verdict with none expected: col %0d row %0d corner %0d",
                 got.col, got.row, got.corner);
          failures++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.corner !== want.corner) begin
            $error("is_corner: expected %0d, got %0d", want.corner, got.corner);
            failures++;
          end
          if (got.col !== want.col) begin
            $error("center_col: expected %0d, got %0d", want.col, got.col);
            failures++;
          end
          if (got.row !== want.row) begin
            $error("center_row: expected %0d, got %0d", want.row, got.row);
            failures++;
          end
          verdicts_checked++;
          if (got.corner === 1'b1) corners_seen++;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fast_corner_detector_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int w, h, m, mind;
    cfg_w = 640;
    cfg_h = 480;
    cfg_m = 10;
    cfg_thr = 51;
    cfg_mind = 10;
    cfg_arc = 12;
    pos_col = 0;
    pos_row = 0;
    for (int k = 0; k < LINES; k++)
      for (int c = 0; c < MAX_WIDTH; c++) line_mem[k][c] = '0;
    for (int y = 0; y < WIN; y++)
      for (int x = 0; x < WIN; x++) win_buf[y][x] = '0;

    //           thr  mind arc center brt  dark fill bright_ring dark_ring verdict
    scenes = '{
      '{ 51,  10, 12,   0,   0,   0,   0, 16'h0000, 16'h0000, 0},  // flat black
      '{ 51,  10, 12, 255, 255, 255, 255, 16'hFFFF, 16'h0000, 0},  // flat white
      '{ 51,  10, 12,   0, 255,   0,   0, 16'hFFFF, 16'h0000, 1},
      '{ 51,  10, 12, 255,   0,   0, 255, 16'h0000, 16'hFFFF, 1},
      '{ 51,  10, 15, 100, 200,   0, 100, 16'hFFDF, 16'h0000, 1},  // run wraps past top
      '{ 51,  10, 15, 100, 200,   0, 100, 16'hFF9F, 16'h0000, 0},
      '{ 51,  10,  0, 100,   0,   0, 100, 16'h0000, 16'h0001, 1},  // zero arc acts as one
      '{ 51, 255, 12,   0, 255,   0,   0, 16'hFFFF, 16'h0000, 0},
      '{511,   0, 12, 128, 255,   0, 128, 16'hFFFF, 16'h0000, 0},  // threshold clamps
      '{511,   0, 12, 128,   0,   0, 128, 16'h0000, 16'hFFFF, 0},
      '{  0,   0, 12, 100, 101,   0, 100, 16'hFFFF, 16'h0000, 1},
      '{  0,  10, 12, 100, 110,   0, 100, 16'hFFFF, 16'h0000, 0},  // on the band edge
      '{ 51,  10,  9, 100, 200,   0, 100, 16'h00FF, 16'hFF00, 0},
      '{ 51,  10,  8, 100, 200,   0, 100, 16'h00FF, 16'hFF00, 1},
      '{ 77,   3,  5,  50,  90,  20,  60, 16'h0F0F, 16'h70F0, PREDICTED},
      '{256,  30,  7, 180, 250,  10, 170, 16'h3C3C, 16'hC0C3, PREDICTED}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An index with no register behind it must change nothing.
    write_reg(REG_UNMAPPED, 'h5A5);

    foreach (scenes[r]) begin
      set_idling();
      apply_config(7, 7, 3, scenes[r].thr, scenes[r].mind, scenes[r].arc);
      forced_corner = (scenes[r].verdict == PREDICTED) ? -1 : scenes[r].verdict;
      for (int y = 0; y < 7; y++)
        for (int x = 0; x < 7; x++)
          push_pixel(scene_pixel(scenes[r], x, y), (x == 0 && y == 0));
      drain_verdicts();
      forced_corner = -1;
    end

    // Register extremes: oversize width and height saturate, margins clamp.
    run_phase(2047, 7, 0, 51, 20, 9, MAX_WIDTH * 7, TEXTURE_SPOTS, 1'b0, 1'b0, 1'b0);
    run_phase(7, 2047, 3, 256, 5, 3, 7 * MAX_HEIGHT, TEXTURE_SPOTS, 1'b0, 1'b0, 1'b0);
    run_phase(3, 5, 3, 51, 10, 12, 40, TEXTURE_NOISE, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 3, 51, 10, 12, 20, TEXTURE_NOISE, 1'b0, 1'b0, 1'b0);
    run_phase(20, 20, 511, 51, 10, 12, 400, TEXTURE_NOISE, 1'b0, 1'b0, 1'b0);
    run_phase(12, 10, 2, 128, 0, 1, 240, TEXTURE_SPOTS, 1'b0, 1'b0, 1'b0);

    // Random settings: the first phase holds the receiver off for a long stretch,
    // the second pauses the sender mid-frame until every verdict is out.
    for (int p = 0; random_pixels < RANDOM_PIXELS; p++) begin
      w = ($urandom_range(7) == 0) ? 17 + $urandom_range(23) : 7 + $urandom_range(9);
      h = 7 + $urandom_range(7);
      m = ($urandom_range(3) == 0) ? $urandom_range(5) : 3;
      mind = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(30);
      run_phase(w, h, m, $urandom_range(511), mind, $urandom_range(15),
                w * h * (1 + $urandom_range(1)),
                ($urandom_range(4) == 0) ? TEXTURE_NOISE : TEXTURE_SPOTS,
                ($urandom_range(3) == 0), (p == 1), (p == 0));
      random_pixels += w * h;
    end

    $display("Streamed %0d pixels over %0d register settings, %0d of them random phases.",
             pixels_sent, phases_run, phases_run - 22);
    $display("Checked %0d verdicts, %0d corners, with %0d mismatches.",
             verdicts_checked, corners_seen, failures);
    if (failures == 0) begin
      $display("fast_corner_detector_unit regression: pass");
    end else begin
      $display("fast_corner_detector_unit regression: fail");
    end
    $finish;
  end

endmodule
